/* rtl/i2c_sensor_register_reader_core_macros.svh */
// Assertion macros for the compass register reader.
// Used by the top level; expects a clock named aclk and a reset named aresetn.
`ifndef I2C_SENSOR_REGISTER_READER_CORE_MACROS_SVH
`define I2C_SENSOR_REGISTER_READER_CORE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ISRR_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("isrr assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define ISRR_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("isrr assertion failed");

`endif

/* rtl/isrr_pkg.sv */
`timescale 1ns / 1ps
// Package for the compass register reader: types, status and action codes, patterns.
// No dependencies.
package isrr_pkg;

    localparam logic [1:0] OP_HEADING = 2'd0;
    localparam logic [1:0] OP_PITCH   = 2'd1;
    localparam logic [1:0] OP_ROLL    = 2'd2;
    localparam logic [1:0] OP_EVENT   = 2'd3;

    localparam logic [1:0] Q_HEADING = 2'd0;
    localparam logic [1:0] Q_PITCH   = 2'd1;
    localparam logic [1:0] Q_ROLL    = 2'd2;

    localparam logic [7:0] ST_START      = 8'h08;
    localparam logic [7:0] ST_REP_START  = 8'h10;
    localparam logic [7:0] ST_MT_SLA_ACK = 8'h18;
    localparam logic [7:0] ST_MT_DAT_ACK = 8'h28;
    localparam logic [7:0] ST_MR_SLA_ACK = 8'h40;
    localparam logic [7:0] ST_MR_DAT_ACK = 8'h50;
    localparam logic [7:0] ST_MR_DAT_NAK = 8'h58;

    localparam logic [2:0] ACT_NONE  = 3'd0;
    localparam logic [2:0] ACT_CONT  = 3'd1;
    localparam logic [2:0] ACT_START = 3'd2;
    localparam logic [2:0] ACT_ACK   = 3'd3;
    localparam logic [2:0] ACT_STOP  = 3'd4;

    localparam logic [1:0] REG_DEVICE_ADDRESS   = 2'd0;
    localparam logic [1:0] REG_HEADING_REGISTER = 2'd1;
    localparam logic [1:0] REG_PITCH_REGISTER   = 2'd2;
    localparam logic [1:0] REG_ROLL_REGISTER    = 2'd3;

    localparam logic [6:0] DEVICE_ADDRESS_RESET   = 7'd96;
    localparam logic [7:0] HEADING_REGISTER_RESET = 8'd2;
    localparam logic [7:0] PITCH_REGISTER_RESET   = 8'd4;
    localparam logic [7:0] ROLL_REGISTER_RESET    = 8'd5;

    localparam logic [15:0] HEADING_PENDING = 16'hFFFF;
    localparam logic [15:0] HEADING_ERROR   = 16'hEEEE;
    localparam logic [7:0]  BYTE_PENDING    = 8'hFF;
    localparam logic [7:0]  BYTE_ERROR      = 8'hBB;

    typedef struct packed {
        logic [6:0] device_address;
        logic [7:0] heading_register;
        logic [7:0] pitch_register;
        logic [7:0] roll_register;
    } cfg_t;

    typedef struct packed {
        logic [1:0]  quantity;
        logic [15:0] heading;
        logic [7:0]  pitch;
        logic [7:0]  roll;
        logic [2:0]  done;
        logic        error;
        logic        active;
    } state_t;

    typedef struct packed {
        logic [7:0] tx_byte;
        logic       tx_load;
        logic [2:0] bus_action;
    } result_t;

endpackage

/* rtl/isrr_cfg.sv */
`timescale 1ns / 1ps
// Configuration register file of the compass register reader.
// Depends on isrr_pkg.
module isrr_cfg (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_valid,
    input  logic [1:0]         cfg_index,
    input  logic [7:0]         cfg_data,
    output isrr_pkg::cfg_t     cfg_o
);

    isrr_pkg::cfg_t cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.device_address   <= isrr_pkg::DEVICE_ADDRESS_RESET;
            cfg_reg.heading_register <= isrr_pkg::HEADING_REGISTER_RESET;
            cfg_reg.pitch_register   <= isrr_pkg::PITCH_REGISTER_RESET;
            cfg_reg.roll_register    <= isrr_pkg::ROLL_REGISTER_RESET;
        end else if (cfg_valid) begin
            case (cfg_index)
                isrr_pkg::REG_DEVICE_ADDRESS:   cfg_reg.device_address   <= cfg_data[6:0];
                isrr_pkg::REG_HEADING_REGISTER: cfg_reg.heading_register <= cfg_data;
                isrr_pkg::REG_PITCH_REGISTER:   cfg_reg.pitch_register   <= cfg_data;
                isrr_pkg::REG_ROLL_REGISTER:    cfg_reg.roll_register    <= cfg_data;
                default: ;
            endcase
        end
    end

    assign cfg_o = cfg_reg;

endmodule

/* rtl/isrr_step.sv */
`timescale 1ns / 1ps
// Combinational sequencer step: decodes one command or bus status event.
// Depends on isrr_pkg.
module isrr_step (
    input  isrr_pkg::cfg_t    cfg_i,
    input  isrr_pkg::state_t  state_i,
    input  logic [1:0]        opcode_i,
    input  logic [7:0]        bus_status_i,
    input  logic [7:0]        rx_byte_i,
    output isrr_pkg::state_t  state_o,
    output isrr_pkg::result_t result_o
);

    always_comb begin
        state_o             = state_i;
        result_o.tx_byte    = 8'd0;
        result_o.tx_load    = 1'b0;
        result_o.bus_action = isrr_pkg::ACT_NONE;

        if (opcode_i != isrr_pkg::OP_EVENT) begin
            if (!state_i.active) begin
                state_o.quantity    = opcode_i;
                state_o.heading     = isrr_pkg::HEADING_PENDING;
                state_o.pitch       = isrr_pkg::BYTE_PENDING;
                state_o.roll        = isrr_pkg::BYTE_PENDING;
                state_o.done        = 3'b000;
                state_o.error       = 1'b0;
                state_o.active      = 1'b1;
                result_o.bus_action = isrr_pkg::ACT_START;
            end
        end else begin
            case (bus_status_i)
                isrr_pkg::ST_START: begin
                    result_o.tx_byte    = {cfg_i.device_address, 1'b0};
                    result_o.tx_load    = 1'b1;
                    result_o.bus_action = isrr_pkg::ACT_CONT;
                end
                isrr_pkg::ST_MT_SLA_ACK: begin
                    case (state_i.quantity)
                        isrr_pkg::Q_HEADING: result_o.tx_byte = cfg_i.heading_register;
                        isrr_pkg::Q_PITCH:   result_o.tx_byte = cfg_i.pitch_register;
                        default:             result_o.tx_byte = cfg_i.roll_register;
                    endcase
                    result_o.tx_load    = 1'b1;
                    result_o.bus_action = isrr_pkg::ACT_CONT;
                end
                isrr_pkg::ST_MT_DAT_ACK: begin
                    result_o.bus_action = isrr_pkg::ACT_START;
                end
                isrr_pkg::ST_REP_START: begin
                    result_o.tx_byte    = {cfg_i.device_address, 1'b1};
                    result_o.tx_load    = 1'b1;
                    result_o.bus_action = isrr_pkg::ACT_CONT;
                end
                isrr_pkg::ST_MR_SLA_ACK: begin
                    result_o.bus_action = (state_i.quantity == isrr_pkg::Q_HEADING) ?
                                          isrr_pkg::ACT_ACK : isrr_pkg::ACT_CONT;
                end
                isrr_pkg::ST_MR_DAT_ACK: begin
                    if (state_i.quantity == isrr_pkg::Q_HEADING) begin
                        state_o.heading = {rx_byte_i, 8'd0};
                    end
                    result_o.bus_action = isrr_pkg::ACT_CONT;
                end
                isrr_pkg::ST_MR_DAT_NAK: begin
                    case (state_i.quantity)
                        isrr_pkg::Q_HEADING: begin
                            state_o.heading = state_i.heading | {8'd0, rx_byte_i};
                            state_o.done[0] = 1'b1;
                            state_o.active  = 1'b0;
                        end
                        isrr_pkg::Q_PITCH: begin
                            state_o.pitch   = rx_byte_i;
                            state_o.done[1] = 1'b1;
                            state_o.active  = 1'b0;
                        end
                        isrr_pkg::Q_ROLL: begin
                            state_o.roll    = rx_byte_i;
                            state_o.done[2] = 1'b1;
                            state_o.active  = 1'b0;
                        end
                        default: begin
                            state_o.error   = 1'b1;
                            state_o.heading = isrr_pkg::HEADING_ERROR;
                            state_o.pitch   = isrr_pkg::BYTE_ERROR;
                            state_o.roll    = isrr_pkg::BYTE_ERROR;
                            state_o.active  = 1'b0;
                        end
                    endcase
                    result_o.bus_action = isrr_pkg::ACT_STOP;
                end
                default: begin
                    state_o.error       = 1'b1;
                    state_o.heading     = isrr_pkg::HEADING_ERROR;
                    state_o.pitch       = isrr_pkg::BYTE_ERROR;
                    state_o.roll        = isrr_pkg::BYTE_ERROR;
                    state_o.active      = 1'b0;
                    result_o.bus_action = isrr_pkg::ACT_STOP;
                end
            endcase
        end
    end

endmodule

/* rtl/i2c_sensor_register_reader_core.sv */
`timescale 1ns / 1ps
// Compass register reader: sequences register reads of an I2C compass from bus status events.
// A command or event is taken every clock cycle when the result side keeps up. Each transfer
// passes an input register, one pass of decode logic and a result register, which loads
// when the output side is free. The readings, flags and busy bit are held in state
// registers that are updated as the result register is loaded, and they drive the reading
// outputs directly. The configuration port is always ready and its writes are registered.
// Depends on isrr_pkg, isrr_cfg, isrr_step and the assertion macro header.
`include "i2c_sensor_register_reader_core_macros.svh"

module i2c_sensor_register_reader_core (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_opcode,
    input  logic [7:0]  s_bus_status,
    input  logic [7:0]  s_rx_byte,

    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_tx_byte,
    output logic        m_tx_load,
    output logic [2:0]  m_bus_action,
    output logic [15:0] m_heading_value,
    output logic [7:0]  m_pitch_value,
    output logic [7:0]  m_roll_value,
    output logic        m_heading_done,
    output logic        m_pitch_done,
    output logic        m_roll_done,
    output logic        m_bus_error,
    output logic        m_busy_res,

    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [7:0]  cfg_data
);

    isrr_pkg::cfg_t    cfg;
    isrr_pkg::state_t  state_reg;
    isrr_pkg::state_t  state_next;
    isrr_pkg::result_t result_reg;
    isrr_pkg::result_t result_next;

    logic       in_valid_reg;
    logic [1:0] opcode_reg;
    logic [7:0] bus_status_reg;
    logic [7:0] rx_byte_reg;
    logic       out_valid_reg;
    logic       advance;
    logic       start_taken;
    logic       start_seen;
    logic       stop_out;
    logic       load_out;

    assign cfg_ready = 1'b1;
    assign advance   = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready   = !in_valid_reg || advance;

    isrr_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg_o     (cfg)
    );

    isrr_step u_step (
        .cfg_i        (cfg),
        .state_i      (state_reg),
        .opcode_i     (opcode_reg),
        .bus_status_i (bus_status_reg),
        .rx_byte_i    (rx_byte_reg),
        .state_o      (state_next),
        .result_o     (result_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            opcode_reg     <= s_opcode;
            bus_status_reg <= s_bus_status;
            rx_byte_reg    <= s_rx_byte;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            result_reg <= result_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg.quantity <= isrr_pkg::Q_HEADING;
            state_reg.heading  <= 16'd0;
            state_reg.pitch    <= 8'd0;
            state_reg.roll     <= 8'd0;
            state_reg.done     <= 3'b000;
            state_reg.error    <= 1'b0;
            state_reg.active   <= 1'b0;
        end else if (advance) begin
            state_reg <= state_next;
        end
    end

    assign m_valid         = out_valid_reg;
    assign m_tx_byte       = result_reg.tx_byte;
    assign m_tx_load       = result_reg.tx_load;
    assign m_bus_action    = result_reg.bus_action;
    assign m_heading_value = state_reg.heading;
    assign m_pitch_value   = state_reg.pitch;
    assign m_roll_value    = state_reg.roll;
    assign m_heading_done  = state_reg.done[0];
    assign m_pitch_done    = state_reg.done[1];
    assign m_roll_done     = state_reg.done[2];
    assign m_bus_error     = state_reg.error;
    assign m_busy_res      = state_reg.active;

    assign start_taken = advance && (opcode_reg != isrr_pkg::OP_EVENT) && !state_reg.active;
    assign start_seen  = state_reg.active && (result_reg.bus_action == isrr_pkg::ACT_START);
    assign stop_out    = out_valid_reg && (result_reg.bus_action == isrr_pkg::ACT_STOP);
    assign load_out    = out_valid_reg && result_reg.tx_load;

    `ISRR_ASSERT_NEXT(a_start_sets_busy, start_taken, start_seen)
    `ISRR_ASSERT_NOW(a_stop_ends_read, stop_out, !state_reg.active)
    `ISRR_ASSERT_NOW(a_load_continues, load_out, result_reg.bus_action == isrr_pkg::ACT_CONT)
    `ISRR_ASSERT_NEXT(a_state_holds, !advance, $stable(state_reg))

endmodule

/* test/testbench.sv */
`timescale 1ns / 1ps
// Self-checking testbench for the compass register reader: directed reads, then random
// well-formed, broken and noisy read sequences under several register settings.
// Depends on isrr_pkg and the i2c_sensor_register_reader_core top level.
module testbench;
    import isrr_pkg::*;

    typedef struct packed {
        logic [1:0] op;
        logic [7:0] status;
        logic [7:0] rx;
    } bus_item_t;

    typedef struct packed {
        logic [7:0]  tx_byte;
        logic        tx_load;
        logic [2:0]  bus_action;
        logic [15:0] heading;
        logic [7:0]  pitch;
        logic [7:0]  roll;
        logic [2:0]  done;
        logic        error;
        logic        busy;
    } reading_t;

    logic        aclk;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [1:0]  s_opcode = OP_EVENT;
    logic [7:0]  s_bus_status = 8'h00;
    logic [7:0]  s_rx_byte = 8'h00;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [7:0]  m_tx_byte;
    logic        m_tx_load;
    logic [2:0]  m_bus_action;
    logic [15:0] m_heading_value;
    logic [7:0]  m_pitch_value;
    logic [7:0]  m_roll_value;
    logic        m_heading_done;
    logic        m_pitch_done;
    logic        m_roll_done;
    logic        m_bus_error;
    logic        m_busy_res;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = REG_DEVICE_ADDRESS;
    logic [7:0]  cfg_data = 8'h00;

    cfg_t        rd_cfg;
    state_t      rd_state;
    reading_t    awaited_responses[$];
    bus_item_t   script[$];
    logic        idle_on = 1'b1;
    int          ready_stall = 0;
    int          error_count = 0;
    int          items_sent = 0;
    int          results_checked = 0;
    int          settings_used = 1;

    i2c_sensor_register_reader_core u_dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_opcode        (s_opcode),
        .s_bus_status    (s_bus_status),
        .s_rx_byte       (s_rx_byte),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_tx_byte       (m_tx_byte),
        .m_tx_load       (m_tx_load),
        .m_bus_action    (m_bus_action),
        .m_heading_value (m_heading_value),
        .m_pitch_value   (m_pitch_value),
        .m_roll_value    (m_roll_value),
        .m_heading_done  (m_heading_done),
        .m_pitch_done    (m_pitch_done),
        .m_roll_done     (m_roll_done),
        .m_bus_error     (m_bus_error),
        .m_busy_res      (m_busy_res),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data)
    );

    always begin
        aclk = 1'b0;
        #10;
        aclk = 1'b1;
        #10;
    end

    function automatic logic [7:0] rand_byte();
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic int pick_gap();
        int r;
        if (!idle_on) return 0;
        r = int'($urandom_range(0, 99));
        if (r < 60) return 0;
        if (r < 94) return int'($urandom_range(1, 3));
        return int'($urandom_range(8, 30));
    endfunction

    function automatic bus_item_t make_item(input logic [1:0] op, input logic [7:0] status,
                                            input logic [7:0] rx);
        bus_item_t it;
        it.op = op;
        it.status = status;
        it.rx = rx;
        return it;
    endfunction

    function automatic logic [7:0] stray_status();
        logic [7:0] s;
        do begin
            s = rand_byte();
        end while (s inside {ST_START, ST_REP_START, ST_MT_SLA_ACK, ST_MT_DAT_ACK,
                             ST_MR_SLA_ACK, ST_MR_DAT_ACK, ST_MR_DAT_NAK});
        return s;
    endfunction

    function automatic void load_error_patterns();
        rd_state.error = 1'b1;
        rd_state.heading = HEADING_ERROR;
        rd_state.pitch = BYTE_ERROR;
        rd_state.roll = BYTE_ERROR;
        rd_state.active = 1'b0;
    endfunction

    // Works out the bus response to one command or status event and advances the readings.
    function automatic reading_t next_bus_response(input logic [1:0] op,
                                                   input logic [7:0] status,
                                                   input logic [7:0] rx);
        reading_t r;
        r = '0;
        r.bus_action = ACT_NONE;
        if (op != OP_EVENT) begin
            if (!rd_state.active) begin
                rd_state.quantity = op;
                rd_state.heading = HEADING_PENDING;
                rd_state.pitch = BYTE_PENDING;
                rd_state.roll = BYTE_PENDING;
                rd_state.done = 3'b000;
                rd_state.error = 1'b0;
                rd_state.active = 1'b1;
                r.bus_action = ACT_START;
            end
        end else begin
            case (status)
                ST_START: begin
                    r.tx_byte = {rd_cfg.device_address, 1'b0};
                    r.tx_load = 1'b1;
                    r.bus_action = ACT_CONT;
                end
                ST_MT_SLA_ACK: begin
                    case (rd_state.quantity)
                        Q_HEADING: r.tx_byte = rd_cfg.heading_register;
                        Q_PITCH:   r.tx_byte = rd_cfg.pitch_register;
                        default:   r.tx_byte = rd_cfg.roll_register;
                    endcase
                    r.tx_load = 1'b1;
                    r.bus_action = ACT_CONT;
                end
                ST_MT_DAT_ACK: r.bus_action = ACT_START;
                ST_REP_START: begin
                    r.tx_byte = {rd_cfg.device_address, 1'b1};
                    r.tx_load = 1'b1;
                    r.bus_action = ACT_CONT;
                end
                ST_MR_SLA_ACK: begin
                    r.bus_action = (rd_state.quantity == Q_HEADING) ? ACT_ACK : ACT_CONT;
                end
                ST_MR_DAT_ACK: begin
                    if (rd_state.quantity == Q_HEADING) rd_state.heading = {rx, 8'h00};
                    r.bus_action = ACT_CONT;
                end
                ST_MR_DAT_NAK: begin
                    case (rd_state.quantity)
                        Q_HEADING: begin
                            rd_state.heading = rd_state.heading | {8'h00, rx};
                            rd_state.done[0] = 1'b1;
                            rd_state.active = 1'b0;
                        end
                        Q_PITCH: begin
                            rd_state.pitch = rx;
                            rd_state.done[1] = 1'b1;
                            rd_state.active = 1'b0;
                        end
                        Q_ROLL: begin
                            rd_state.roll = rx;
                            rd_state.done[2] = 1'b1;
                            rd_state.active = 1'b0;
                        end
                        default: load_error_patterns();
                    endcase
                    r.bus_action = ACT_STOP;
                end
                default: begin
                    load_error_patterns();
                    r.bus_action = ACT_STOP;
                end
            endcase
        end
        r.heading = rd_state.heading;
        r.pitch = rd_state.pitch;
        r.roll = rd_state.roll;
        r.done = rd_state.done;
        r.error = rd_state.error;
        r.busy = rd_state.active;
        return r;
    endfunction

    task automatic send_item(input bus_item_t it);
        int gap;
        gap = pick_gap();
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_opcode <= it.op;
        s_bus_status <= it.status;
        s_rx_byte <= it.rx;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        awaited_responses.push_back(next_bus_response(it.op, it.status, it.rx));
        items_sent++;
    endtask

    task automatic wait_for_quiet();
        s_valid <= 1'b0;
        while (awaited_responses.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic program_registers(input logic [7:0] address, input logic [7:0] heading,
                                     input logic [7:0] pitch, input logic [7:0] roll);
        logic [1:0] indices [0:3];
        logic [7:0] words [0:3];
        indices = '{REG_DEVICE_ADDRESS, REG_HEADING_REGISTER, REG_PITCH_REGISTER,
                    REG_ROLL_REGISTER};
        words = '{address, heading, pitch, roll};
        wait_for_quiet();
        for (int i = 0; i < 4; i++) begin
            cfg_valid <= 1'b1;
            cfg_index <= indices[i];
            cfg_data <= words[i];
            @(posedge aclk);
            while (!cfg_ready) @(posedge aclk);
        end
        cfg_valid <= 1'b0;
        rd_cfg.device_address = address[6:0];
        rd_cfg.heading_register = heading;
        rd_cfg.pitch_register = pitch;
        rd_cfg.roll_register = roll;
        settings_used++;
    endtask

    task automatic compose_read(input logic [1:0] which);
        script.delete();
        script.push_back(make_item(which, rand_byte(), rand_byte()));
        script.push_back(make_item(OP_EVENT, ST_START, rand_byte()));
        script.push_back(make_item(OP_EVENT, ST_MT_SLA_ACK, rand_byte()));
        script.push_back(make_item(OP_EVENT, ST_MT_DAT_ACK, rand_byte()));
        script.push_back(make_item(OP_EVENT, ST_REP_START, rand_byte()));
        script.push_back(make_item(OP_EVENT, ST_MR_SLA_ACK, rand_byte()));
        if (which == OP_HEADING || $urandom_range(0, 9) == 0) begin
            script.push_back(make_item(OP_EVENT, ST_MR_DAT_ACK, rand_byte()));
        end
        script.push_back(make_item(OP_EVENT, ST_MR_DAT_NAK, rand_byte()));
    endtask

    // Mostly complete reads; some carry a stray start command, some break off with an
    // unexpected status, and some are replaced by random noise.
    task automatic run_read_sequences(input int count);
        int stop_at;
        int kind;
        int keep;
        int extra_at;
        stop_at = items_sent + count;
        while (items_sent < stop_at) begin
            kind = int'($urandom_range(0, 99));
            compose_read(2'($urandom_range(0, 2)));
            keep = script.size();
            extra_at = -1;
            if (kind < 10) begin
                extra_at = int'($urandom_range(1, script.size() - 1));
            end else if (kind < 22) begin
                keep = int'($urandom_range(1, script.size() - 1));
            end
            if (kind >= 88) begin
                repeat ($urandom_range(1, 4)) begin
                    send_item(make_item(2'($urandom_range(0, 3)), rand_byte(), rand_byte()));
                end
            end else begin
                for (int i = 0; i < keep; i++) begin
                    if (i == extra_at) begin
                        send_item(make_item(2'($urandom_range(0, 2)), rand_byte(), rand_byte()));
                    end
                    send_item(script[i]);
                end
                if (keep < script.size()) begin
                    send_item(make_item(OP_EVENT, stray_status(), rand_byte()));
                end
            end
            if ($urandom_range(0, 39) == 0) wait_for_quiet();
            if ($urandom_range(0, 29) == 0) idle_on = !idle_on;
        end
    endtask

    task automatic test_idle_events();
        // A final byte with no high byte before it, straight after reset with heading selected.
        send_item(make_item(OP_EVENT, ST_MR_DAT_NAK, 8'h5A));
        send_item(make_item(OP_EVENT, 8'h00, 8'h00));
    endtask

    task automatic test_heading_read();
        send_item(make_item(OP_HEADING, 8'hFF, 8'hFF));
        send_item(make_item(OP_EVENT, ST_START, 8'h00));
        send_item(make_item(OP_EVENT, ST_MT_SLA_ACK, 8'h00));
        send_item(make_item(OP_EVENT, ST_MT_DAT_ACK, 8'h00));
        send_item(make_item(OP_EVENT, ST_REP_START, 8'h00));
        send_item(make_item(OP_EVENT, ST_MR_SLA_ACK, 8'h00));
        send_item(make_item(OP_EVENT, ST_MR_DAT_ACK, 8'hFF));
        send_item(make_item(OP_EVENT, ST_MR_DAT_NAK, 8'h00));
    endtask

    task automatic test_start_while_busy();
        send_item(make_item(OP_PITCH, 8'h00, 8'h00));
        send_item(make_item(OP_ROLL, 8'hFF, 8'hFF));
        send_item(make_item(OP_EVENT, ST_START, 8'h00));
        send_item(make_item(OP_EVENT, 8'hFF, 8'hFF));
    endtask

    task automatic test_discarded_ack_byte();
        send_item(make_item(OP_ROLL, 8'h00, 8'h00));
        send_item(make_item(OP_EVENT, ST_START, 8'h00));
        send_item(make_item(OP_EVENT, ST_MT_SLA_ACK, 8'h00));
        send_item(make_item(OP_EVENT, ST_MT_DAT_ACK, 8'h00));
        send_item(make_item(OP_EVENT, ST_REP_START, 8'h00));
        send_item(make_item(OP_EVENT, ST_MR_SLA_ACK, 8'h00));
        send_item(make_item(OP_EVENT, ST_MR_DAT_ACK, 8'h00));
        send_item(make_item(OP_EVENT, ST_MR_DAT_NAK, 8'h80));
    endtask

    task automatic test_default_registers();
        run_read_sequences(250);
    endtask

    task automatic test_register_extremes();
        program_registers(8'h00, 8'h00, 8'h00, 8'h00);
        run_read_sequences(200);
        program_registers(8'hFF, 8'hFF, 8'hFF, 8'hFF);
        run_read_sequences(200);
    endtask

    task automatic test_random_registers();
        repeat (4) begin
            program_registers(rand_byte(), rand_byte(), rand_byte(), rand_byte());
            run_read_sequences(200);
        end
    endtask

    task automatic test_back_to_back();
        wait_for_quiet();
        idle_on = 1'b0;
        run_read_sequences(200);
        idle_on = 1'b1;
    endtask

    always @(posedge aclk) begin
        if (ready_stall != 0) begin
            ready_stall <= ready_stall - 1;
            m_ready <= 1'b0;
        end else begin
            ready_stall <= pick_gap();
            m_ready <= 1'b1;
        end
    end

    task automatic compare_field(input string label, input logic [15:0] want,
                                 input logic [15:0] got);
        if (got !== want) begin
            error_count++;
            $display("%0t: %s mismatch, expected %h actual %h", $time, label, want, got);
        end
    endtask

    always @(posedge aclk) begin
        reading_t want;
        if (aresetn && m_valid && m_ready) begin
            if (awaited_responses.size() == 0) begin
                error_count++;
                $display("%0t: result transfer with nothing expected, tx_byte %h action %0d",
                         $time, m_tx_byte, m_bus_action);
            end else begin
                want = awaited_responses.pop_front();
                compare_field("tx_byte", 16'(want.tx_byte), 16'(m_tx_byte));
                compare_field("tx_load", 16'(want.tx_load), 16'(m_tx_load));
                compare_field("bus_action", 16'(want.bus_action), 16'(m_bus_action));
                compare_field("heading_value", want.heading, m_heading_value);
                compare_field("pitch_value", 16'(want.pitch), 16'(m_pitch_value));
                compare_field("roll_value", 16'(want.roll), 16'(m_roll_value));
                compare_field("heading_done", 16'(want.done[0]), 16'(m_heading_done));
                compare_field("pitch_done", 16'(want.done[1]), 16'(m_pitch_done));
                compare_field("roll_done", 16'(want.done[2]), 16'(m_roll_done));
                compare_field("bus_error", 16'(want.error), 16'(m_bus_error));
                compare_field("busy_res", 16'(want.busy), 16'(m_busy_res));
                results_checked++;
            end
        end
    end

    initial begin
        rd_cfg.device_address = DEVICE_ADDRESS_RESET;
        rd_cfg.heading_register = HEADING_REGISTER_RESET;
        rd_cfg.pitch_register = PITCH_REGISTER_RESET;
        rd_cfg.roll_register = ROLL_REGISTER_RESET;
        rd_state = '0;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_idle_events();
        test_heading_read();
        test_start_while_busy();
        test_discarded_ack_byte();
        test_default_registers();
        test_register_extremes();
        test_random_registers();
        test_back_to_back();

        wait_for_quiet();
        repeat (8) @(posedge aclk);
        if (awaited_responses.size() != 0) begin
            error_count++;
            $display("%0t: %0d expected results never arrived", $time, awaited_responses.size());
        end
        $display("Sent %0d items, checked %0d results under %0d register settings.",
                 items_sent, results_checked, settings_used);
        $display("Covered full, interrupted and noisy reads of heading, pitch and roll.");
        if (error_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

    initial begin
        #10_000_000;
        $display("%0t: run timed out", $time);
        $display("Regression FAIL");
        $finish;
    end

endmodule
